### sv/evp_pkg.sv
package evp_pkg;

    // field widths
    localparam int WORD_W   = 16;
    localparam int LEN_W    = 13;
    localparam int KIND_W   = 3;
    localparam int SAMPLE_W = 17;
    localparam int TS_W     = 48;
    localparam int SLOT_W   = 4;

    // queue between the parser and the field unit
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [WORD_W-1:0]            MARKER       = 16'hAAAA;
    localparam logic signed [SAMPLE_W-1:0]   TRACE_OFFSET = 17'sd512;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LAST     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_MARK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LEN_ERR  = 3'd4;

    // word positions inside the event header (low four bits of the position)
    localparam logic [SLOT_W-1:0] SLOT_BOARD    = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_CHAN     = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_LED_MID  = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_LED_LO   = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_ENERGY   = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_LED_HI   = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_CFD_LO   = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_EN_FLAGS = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_CFD_HI   = 4'd11;
    localparam logic [SLOT_W-1:0] SLOT_CFD_MID  = 4'd12;
    localparam logic [SLOT_W-1:0] SLOT_P1_LO    = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_P1_HI    = 4'd14;
    localparam logic [SLOT_W-1:0] SLOT_P2_LO    = 4'd15;

    typedef enum logic [2:0] {
        OP_CAPTURE,
        OP_HEADER,
        OP_SAMPLE,
        OP_LAST,
        OP_NO_MARK,
        OP_LEN_ERR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  word;
    } q_entry_t;

endpackage

### sv/digitizer_event_word_parser_core.sv
// digitizer event word parser
// input channel: in_valid / in_stall with event_word, declared_words and
//   first_word; one request is one 16-bit event word, first_word restarts the
//   parser and latches declared_words as the event length
// output channel: out_valid / out_stall with kind and the header and sample
//   fields; a word gives at most one result (header after word sixteen, one
//   sample per trace word, or an error that drops the rest of the event)
// throughput: one word per cycle while in_stall is low; no word type
//   needs more than one pass through the field unit
// path: a result goes from the parser into the two-entry queue, then
//   from the field unit into the output register
// stall: while out_stall holds, the result waits in the output register and
//   field-capture words still drain; words that produce results back up in
//   the queue and in_stall rises once the queue's two entries are full
// reset: the parser waits for a first word, queue and output are empty
module digitizer_event_word_parser_core
    import evp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // word requests
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [WORD_W-1:0]           event_word,
    input  logic [LEN_W-1:0]            declared_words,
    input  logic                        first_word,
    // result requests
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [KIND_W-1:0]           kind,
    output logic [4:0]                  board_num,
    output logic [3:0]                  channel,
    output logic [11:0]                 module_res,
    output logic [TS_W-1:0]             led_timestamp,
    output logic [23:0]                 energy,
    output logic                        energy_sign,
    output logic                        pileup,
    output logic [TS_W-1:0]             cfd_timestamp,
    output logic [31:0]                 cfd_point_one,
    output logic [31:0]                 cfd_point_two,
    output logic signed [SAMPLE_W-1:0]  sample
);

    // parser to queue
    logic      push;
    q_entry_t  push_entry;
    logic      q_full;

    // queue to field unit
    logic      q_valid;
    q_entry_t  q_head;
    logic      pop;

    // parser: tracks word position and event state, classifies each word
    evp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .event_word     (event_word),
        .declared_words (declared_words),
        .first_word     (first_word),
        .q_full         (q_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    // decouples the parser from output backpressure
    evp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_head     (q_head)
    );

    // field unit: captures header words, builds header, samples and errors
    evp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .board_num     (board_num),
        .channel       (channel),
        .module_res    (module_res),
        .led_timestamp (led_timestamp),
        .energy        (energy),
        .energy_sign   (energy_sign),
        .pileup        (pileup),
        .cfd_timestamp (cfd_timestamp),
        .cfd_point_one (cfd_point_one),
        .cfd_point_two (cfd_point_two),
        .sample        (sample)
    );

endmodule

### sv/evp_front.sv
module evp_front
    import evp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [WORD_W-1:0]  event_word,
    input  logic [LEN_W-1:0]   declared_words,
    input  logic               first_word,
    input  logic               q_full,
    output logic               push,
    output q_entry_t           push_entry
);

    localparam logic [LEN_W:0] N_MARK_A = 14'd1;
    localparam logic [LEN_W:0] N_MARK_B = 14'd2;
    localparam logic [LEN_W:0] N_LEN    = 14'd3;
    localparam logic [LEN_W:0] N_HDR_HI = 14'd15;
    localparam logic [LEN_W:0] N_HEADER = 14'd16;

    logic [LEN_W-1:0] word_index_reg, word_index_next;
    logic             skipping_reg, skipping_next;
    logic [LEN_W-1:0] event_length_reg, event_length_next;

    logic             accept;
    logic [LEN_W-1:0] idx_eff;
    logic             skip_eff;
    logic [LEN_W:0]   n;
    logic [LEN_W-1:0] enc_len;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        idx_eff           = first_word ? '0 : word_index_reg;
        skip_eff          = first_word ? 1'b0 : skipping_reg;
        event_length_next = first_word ? declared_words : event_length_reg;
        n                 = {1'b0, idx_eff} + 14'd1;
        enc_len           = {1'b0, event_word[10:0], 1'b0} + 13'd2;

        word_index_next   = idx_eff;
        skipping_next     = skip_eff;
        push              = 1'b0;
        push_entry.op     = OP_CAPTURE;
        push_entry.slot   = n[SLOT_W-1:0];
        push_entry.word   = event_word;

        if (!skip_eff)
        begin
            word_index_next = n[LEN_W-1:0];
            push            = 1'b1;
            case (n)
                N_MARK_A, N_MARK_B:
                begin
                    if (event_word != MARKER)
                    begin
                        push_entry.op = OP_NO_MARK;
                        skipping_next = 1'b1;
                    end
                    else
                    begin
                        push = 1'b0;
                    end
                end
                N_LEN:
                begin
                    if (enc_len != event_length_next)
                    begin
                        push_entry.op = OP_LEN_ERR;
                        skipping_next = 1'b1;
                    end
                    else if (enc_len < 13'd16)
                    begin
                        skipping_next = 1'b1;
                    end
                end
                N_HEADER:
                begin
                    push_entry.op = OP_HEADER;
                    if (event_length_next <= 13'd16)
                        skipping_next = 1'b1;
                end
                default:
                begin
                    if (n > N_HDR_HI)
                    begin
                        if (n >= {1'b0, event_length_next})
                        begin
                            push_entry.op = OP_LAST;
                            skipping_next = 1'b1;
                        end
                        else
                        begin
                            push_entry.op = OP_SAMPLE;
                        end
                    end
                end
            endcase
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg   <= '0;
            skipping_reg     <= 1'b1;
            event_length_reg <= '0;
        end
        else if (accept)
        begin
            word_index_reg   <= word_index_next;
            skipping_reg     <= skipping_next;
            event_length_reg <= event_length_next;
        end
    end

    a_first_word_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first_word |=> word_index_reg == 13'd1)
        else $error("first word did not restart the parser");

    a_skip_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
        accept && skipping_reg && !first_word |=> $stable(word_index_reg) && skipping_reg)
        else $error("parser moved while skipping");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("request pushed into a full queue");

endmodule

### sv/evp_queue.sv
module evp_queue
    import evp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output logic      q_full,
    output logic      q_valid,
    output q_entry_t  q_head
);

    q_entry_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/evp_back.sv
module evp_back
    import evp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  q_entry_t                    q_head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [KIND_W-1:0]           kind,
    output logic [4:0]                  board_num,
    output logic [3:0]                  channel,
    output logic [11:0]                 module_res,
    output logic [TS_W-1:0]             led_timestamp,
    output logic [23:0]                 energy,
    output logic                        energy_sign,
    output logic                        pileup,
    output logic [TS_W-1:0]             cfd_timestamp,
    output logic [31:0]                 cfd_point_one,
    output logic [31:0]                 cfd_point_two,
    output logic signed [SAMPLE_W-1:0]  sample
);

    // captured header fields
    logic [4:0]         board_reg;
    logic [3:0]         channel_reg;
    logic [11:0]        module_reg;
    logic [TS_W-1:0]    led_ts_reg;
    logic [25:0]        energy_reg;
    logic [TS_W-1:0]    cfd_ts_reg;
    logic [31:0]        cfd_one_reg;
    logic [15:0]        cfd_two_lo_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]           kind_reg;
    logic [4:0]                  board_num_reg;
    logic [3:0]                  channel_out_reg;
    logic [11:0]                 module_res_reg;
    logic [TS_W-1:0]             led_out_reg;
    logic [23:0]                 energy_out_reg;
    logic                        energy_sign_reg;
    logic                        pileup_reg;
    logic [TS_W-1:0]             cfd_out_reg;
    logic [31:0]                 cfd_one_out_reg;
    logic [31:0]                 cfd_two_out_reg;
    logic signed [SAMPLE_W-1:0]  sample_reg;

    logic                        out_free;
    logic                        emits;
    logic                        load;
    logic                        is_hdr;
    logic                        is_smp;
    logic [WORD_W-1:0]           w;
    logic signed [SAMPLE_W-1:0]  sample_calc;

    assign w           = q_head.word;
    assign out_free    = !out_valid_reg || !out_stall;
    assign emits       = (q_head.op != OP_CAPTURE);
    assign pop         = q_valid && (!emits || out_free);
    assign load        = q_valid && emits && out_free;
    assign is_hdr      = (q_head.op == OP_HEADER);
    assign is_smp      = (q_head.op == OP_SAMPLE) || (q_head.op == OP_LAST);
    assign sample_calc = TRACE_OFFSET - $signed({w[15], w});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // header field capture
    always_ff @(posedge clk)
    begin
        if (pop && !emits)
        begin
            case (q_head.slot)
                SLOT_BOARD:    board_reg <= w[15:11];
                SLOT_CHAN:
                begin
                    channel_reg <= w[3:0];
                    module_reg  <= w[15:4];
                end
                SLOT_LED_MID:  led_ts_reg[31:16] <= w;
                SLOT_LED_LO:   led_ts_reg[15:0]  <= w;
                SLOT_ENERGY:   energy_reg[15:0]  <= w;
                SLOT_LED_HI:   led_ts_reg[47:32] <= w;
                SLOT_CFD_LO:   cfd_ts_reg[15:0]  <= w;
                SLOT_EN_FLAGS: energy_reg[25:16] <= {w[15], w[8], w[7:0]};
                SLOT_CFD_HI:   cfd_ts_reg[47:32] <= w;
                SLOT_CFD_MID:  cfd_ts_reg[31:16] <= w;
                SLOT_P1_LO:    cfd_one_reg[15:0]  <= w;
                SLOT_P1_HI:    cfd_one_reg[31:16] <= w;
                SLOT_P2_LO:    cfd_two_lo_reg     <= w;
                default:       board_reg <= board_reg;
            endcase
        end
    end

    // result payload, header fields only in a header, sample only in samples
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            board_num_reg   <= is_hdr ? board_reg : '0;
            channel_out_reg <= is_hdr ? channel_reg : '0;
            module_res_reg  <= is_hdr ? module_reg : '0;
            led_out_reg     <= is_hdr ? led_ts_reg : '0;
            energy_out_reg  <= is_hdr ? energy_reg[23:0] : '0;
            energy_sign_reg <= is_hdr && energy_reg[24];
            pileup_reg      <= is_hdr && energy_reg[25];
            cfd_out_reg     <= is_hdr ? cfd_ts_reg : '0;
            cfd_one_out_reg <= is_hdr ? cfd_one_reg : '0;
            cfd_two_out_reg <= is_hdr ? {w, cfd_two_lo_reg} : '0;
            sample_reg      <= is_smp ? sample_calc : '0;
            case (q_head.op)
                OP_HEADER:  kind_reg <= KIND_HEADER;
                OP_SAMPLE:  kind_reg <= KIND_SAMPLE;
                OP_LAST:    kind_reg <= KIND_LAST;
                OP_NO_MARK: kind_reg <= KIND_NO_MARK;
                OP_LEN_ERR: kind_reg <= KIND_LEN_ERR;
                default:    kind_reg <= KIND_LEN_ERR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign board_num     = board_num_reg;
    assign channel       = channel_out_reg;
    assign module_res    = module_res_reg;
    assign led_timestamp = led_out_reg;
    assign energy        = energy_out_reg;
    assign energy_sign   = energy_sign_reg;
    assign pileup        = pileup_reg;
    assign cfd_timestamp = cfd_out_reg;
    assign cfd_point_one = cfd_one_out_reg;
    assign cfd_point_two = cfd_two_out_reg;
    assign sample        = sample_reg;

endmodule
